FILE: rtl/sotp_pkg.sv
package sotp_pkg;

   // Result status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_SHORT  = 2'd1;
   localparam logic [1:0] STATUS_LENGTH = 2'd2;

   localparam logic [29:0] MAX_ELEMENTS_RESET = 30'd1024;

   // Result queue: two entries of headroom for one header byte, two for the output side.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        list_start;
      logic [31:0] buffer_size;
   } req_payload_type;

   typedef struct packed {
      logic [29:0] element_index;
      logic [31:0] slice_start;
      logic [31:0] slice_length;
      logic [29:0] element_count;
      logic [1:0]  status;
      logic        last;
   } rsp_payload_type;

   function automatic rsp_payload_type make_rsp(
      input logic [29:0] index,
      input logic [31:0] start,
      input logic [31:0] size,
      input logic [29:0] count,
      input logic [1:0]  status,
      input logic        last
   );
      rsp_payload_type r;
      r.element_index = index;
      r.slice_start   = start;
      r.slice_length  = size;
      r.element_count = count;
      r.status        = status;
      r.last          = last;
      return r;
   endfunction

endpackage

FILE: rtl/ssz_offset_table_parser_top.sv
// Channel   Direction  Handshake            Beat contents
// req_      in         req_valid/req_ready  one header byte, list start mark, buffer size
// rsp_      out        rsp_valid/rsp_ready  one slice report or error code
// csr_      in         csr_valid/csr_ready  max_elements (30 bits)
//
// Each request beat is decoded in the cycle it is accepted: the parser state and
// up to two result beats are written at that edge, the results into a four-entry
// queue that drives the response channel. One request beat per cycle is sustained
// while the queue holds two or fewer results; a stalled response side fills the
// queue and then holds req_ready low. csr_ready is always high. Reset is
// synchronous and leaves the parser idle, waiting for a list start, with
// max_elements at 1024.
module ssz_offset_table_parser_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  sotp_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output sotp_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [29:0]               csr_data
);
   import sotp_pkg::*;

   // Configuration register
   logic [29:0] max_elements_ff;

   // Parser state
   logic [23:0] byte_buffer_ff,     byte_buffer_in;
   logic [1:0]  byte_phase_ff,      byte_phase_in;
   logic [31:0] bytes_seen_ff,      bytes_seen_in;
   logic [31:0] total_size_ff,      total_size_in;
   logic [31:0] previous_offset_ff, previous_offset_in;
   logic [29:0] count_held_ff,      count_held_in;
   logic [29:0] next_index_ff,      next_index_in;
   logic        list_done_ff,       list_done_in;

   // Result queue
   rsp_payload_type           queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]    fill_ff,   fill_in;

   logic            req_accept;
   logic            rsp_pop;
   rsp_payload_type res0;
   rsp_payload_type res1;
   logic [1:0]      res_count;
   logic [31:0]     offset;
   logic            too_short;

   assign csr_ready  = 1'b1;
   // Room for the two results that a single byte can raise.
   assign req_ready  = fill_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = fill_ff != '0;
   assign rsp_data   = queue_ff[rd_ptr_ff];
   assign rsp_pop    = rsp_valid && rsp_ready;

   // Decode of one header byte. Blocking updates let a list start clear the
   // state before the same byte is looked at.
   always_comb begin
      byte_buffer_in     = byte_buffer_ff;
      byte_phase_in      = byte_phase_ff;
      bytes_seen_in      = bytes_seen_ff;
      total_size_in      = total_size_ff;
      previous_offset_in = previous_offset_ff;
      count_held_in      = count_held_ff;
      next_index_in      = next_index_ff;
      list_done_in       = list_done_ff;
      res0               = '0;
      res1               = '0;
      res_count          = 2'd0;
      offset             = '0;
      too_short          = 1'b0;

      if (req_accept) begin
         if (req_data.list_start) begin
            total_size_in      = req_data.buffer_size;
            byte_buffer_in     = '0;
            byte_phase_in      = '0;
            bytes_seen_in      = '0;
            previous_offset_in = '0;
            count_held_in      = '0;
            next_index_in      = '0;
            list_done_in       = 1'b0;
            if (req_data.buffer_size == 32'd0) begin
               // An empty list is complete before any byte arrives.
               res0         = make_rsp('0, '0, '0, '0, STATUS_OK, 1'b1);
               res_count    = 2'd1;
               list_done_in = 1'b1;
            end else if (req_data.buffer_size < 32'd4) begin
               res0         = make_rsp('0, '0, '0, '0, STATUS_SHORT, 1'b1);
               res_count    = 2'd1;
               list_done_in = 1'b1;
            end
         end

         if (!list_done_in) begin
            bytes_seen_in = bytes_seen_in + 32'd1;
            // Another offset must still fit inside the buffer.
            too_short = ({1'b0, bytes_seen_in} + 33'd4) > {1'b0, total_size_in};
            if (byte_phase_in != 2'd3) begin
               byte_buffer_in = byte_buffer_in
                              | (24'(req_data.data_byte) << {byte_phase_in, 3'b000});
               byte_phase_in  = byte_phase_in + 2'd1;
            end else begin
               offset         = {req_data.data_byte, byte_buffer_in};
               byte_buffer_in = '0;
               byte_phase_in  = '0;
               if (bytes_seen_in == 32'd4) begin
                  // The first offset gives the element count.
                  if (offset[1:0] != 2'd0) begin
                     res0         = make_rsp(next_index_in, '0, '0, '0, STATUS_LENGTH, 1'b1);
                     res_count    = 2'd1;
                     list_done_in = 1'b1;
                  end else if (offset[31:2] > max_elements_ff) begin
                     res0 = make_rsp(next_index_in, '0, '0, offset[31:2], STATUS_LENGTH, 1'b1);
                     res_count    = 2'd1;
                     list_done_in = 1'b1;
                  end else if (offset[31:2] == 30'd0) begin
                     res0         = make_rsp('0, '0, '0, '0, STATUS_OK, 1'b1);
                     res_count    = 2'd1;
                     list_done_in = 1'b1;
                  end else begin
                     count_held_in      = offset[31:2];
                     previous_offset_in = offset;
                     next_index_in      = '0;
                     if (count_held_in == 30'd1) begin
                        // A single element runs to the end of the buffer.
                        if (total_size_in < offset) begin
                           res0 = make_rsp(next_index_in, '0, '0, count_held_in,
                                           STATUS_LENGTH, 1'b1);
                        end else begin
                           res0 = make_rsp(next_index_in, offset, total_size_in - offset,
                                           count_held_in, STATUS_OK, 1'b1);
                        end
                        res_count    = 2'd1;
                        list_done_in = 1'b1;
                     end else if (too_short) begin
                        res0 = make_rsp(next_index_in, '0, '0, count_held_in,
                                        STATUS_SHORT, 1'b1);
                        res_count    = 2'd1;
                        list_done_in = 1'b1;
                     end
                  end
               end else begin
                  // A later offset closes the current slice.
                  if (offset < previous_offset_in || offset > total_size_in) begin
                     res0 = make_rsp(next_index_in, '0, '0, count_held_in,
                                     STATUS_LENGTH, 1'b1);
                     res_count    = 2'd1;
                     list_done_in = 1'b1;
                  end else begin
                     res0 = make_rsp(next_index_in, previous_offset_in,
                                     offset - previous_offset_in, count_held_in,
                                     STATUS_OK, 1'b0);
                     res_count          = 2'd1;
                     previous_offset_in = offset;
                     next_index_in      = next_index_in + 30'd1;
                     if (next_index_in == count_held_in - 30'd1) begin
                        // The final slice ends at the buffer size.
                        res1 = make_rsp(next_index_in, offset, total_size_in - offset,
                                        count_held_in, STATUS_OK, 1'b1);
                        res_count    = 2'd2;
                        list_done_in = 1'b1;
                     end else if (too_short) begin
                        res1 = make_rsp(next_index_in, '0, '0, count_held_in,
                                        STATUS_SHORT, 1'b1);
                        res_count    = 2'd2;
                        list_done_in = 1'b1;
                     end
                  end
               end
            end
         end
      end
   end

   // Queue pointers and fill level.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(res_count);
      rd_ptr_in = rsp_pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + QUEUE_CNT_W'(res_count) - QUEUE_CNT_W'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (res_count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (res_count == 2'd2) begin
         queue_ff[wr_ptr_ff + QUEUE_PTR_W'(1)] <= res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_elements_ff    <= MAX_ELEMENTS_RESET;
         byte_buffer_ff     <= '0;
         byte_phase_ff      <= '0;
         bytes_seen_ff      <= '0;
         total_size_ff      <= '0;
         previous_offset_ff <= '0;
         count_held_ff      <= '0;
         next_index_ff      <= '0;
         list_done_ff       <= 1'b1;
         wr_ptr_ff          <= '0;
         rd_ptr_ff          <= '0;
         fill_ff            <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            max_elements_ff <= csr_data;
         end
         byte_buffer_ff     <= byte_buffer_in;
         byte_phase_ff      <= byte_phase_in;
         bytes_seen_ff      <= bytes_seen_in;
         total_size_ff      <= total_size_in;
         previous_offset_ff <= previous_offset_in;
         count_held_ff      <= count_held_in;
         next_index_ff      <= next_index_in;
         list_done_ff       <= list_done_in;
         wr_ptr_ff          <= wr_ptr_in;
         rd_ptr_ff          <= rd_ptr_in;
         fill_ff            <= fill_in;
      end
   end

endmodule

FILE: test/tb_ssz_offset_table_parser_top.sv
`timescale 1ns / 100ps

// Self-checking bench for the SSZ offset table parser. Header bytes are fed in as request
// beats, one byte per beat, and every response beat is compared against a local model of
// the parser that runs on each accepted request beat.
module tb_ssz_offset_table_parser_top;
   import sotp_pkg::*;

   // The kinds of list that the random stimulus builds. Most lists are well formed; the
   // rest carry one deliberate defect each, or are plain line noise.
   typedef enum {
      FLAW_NONE,
      FLAW_MISALIGN,
      FLAW_OVERCOUNT,
      FLAW_BACKWARD,
      FLAW_BEYOND,
      FLAW_TRUNCATE,
      FLAW_RESTART,
      FLAW_NOISE
   } list_flaw_type;

   logic            clock;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [29:0]     csr_data  = '0;

   // Request beats waiting to be driven, and the slice reports still owed by the parser.
   req_payload_type header_beats [$];
   rsp_payload_type slice_expect [$];

   int unsigned beats_queued   = 0;
   int unsigned beats_taken    = 0;
   int unsigned header_count   = 0;
   int unsigned mismatch_count = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   // Our own copy of the parser state and of the element limit register.
   logic [23:0] word_bytes    = '0;
   logic [1:0]  word_phase    = '0;
   logic [31:0] header_seen   = '0;
   logic [31:0] list_size     = '0;
   logic [31:0] prev_boundary = '0;
   logic [29:0] list_count    = '0;
   logic [29:0] elem_index    = '0;
   logic        list_idle     = 1'b1;
   logic [29:0] max_elems     = MAX_ELEMENTS_RESET;

   ssz_offset_table_parser_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A generous ceiling on the whole run.
   initial begin
      #2_000_000;
      $display("[ssz_offset_table_parser_top] ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------------------
   // Model of the parser
   // ------------------------------------------------------------------------------------

   function automatic void expect_slice(input logic [29:0] index, input logic [31:0] start,
                                        input logic [31:0] size, input logic [29:0] count,
                                        input logic [1:0] status, input logic final_mark);
      rsp_payload_type r;
      r.element_index = index;
      r.slice_start   = start;
      r.slice_length  = size;
      r.element_count = count;
      r.status        = status;
      r.last          = final_mark;
      slice_expect.push_back(r);
   endfunction

   // An error report always names the element in hand, carries no slice and ends the list.
   function automatic void abort_list(input logic [1:0] status, input logic [29:0] count);
      expect_slice(elem_index, '0, '0, count, status, 1'b1);
      list_idle = 1'b1;
   endfunction

   // Once the start of the current element is known, either the final slice closes at the
   // end of the buffer, or there must be room for one more offset in the buffer.
   function automatic void close_or_await();
      if (elem_index == list_count - 30'd1) begin
         if (list_size < prev_boundary) begin
            abort_list(STATUS_LENGTH, list_count);
         end else begin
            expect_slice(elem_index, prev_boundary, list_size - prev_boundary, list_count,
                         STATUS_OK, 1'b1);
            list_idle = 1'b1;
         end
      end else if ({1'b0, header_seen} + 33'd4 > {1'b0, list_size}) begin
         abort_list(STATUS_SHORT, list_count);
      end
   endfunction

   function automatic void predict_header_byte(input req_payload_type beat);
      logic [31:0] word;
      if (beat.list_start) begin
         list_size     = beat.buffer_size;
         word_bytes    = '0;
         word_phase    = '0;
         header_seen   = '0;
         prev_boundary = '0;
         list_count    = '0;
         elem_index    = '0;
         list_idle     = 1'b0;
         if (list_size == 32'd0) begin
            expect_slice('0, '0, '0, '0, STATUS_OK, 1'b1);
            list_idle = 1'b1;
            return;
         end
         if (list_size < 32'd4) begin
            abort_list(STATUS_SHORT, '0);
            return;
         end
      end
      if (list_idle)
         return;
      header_seen = header_seen + 32'd1;
      if (word_phase < 2'd3) begin
         word_bytes = word_bytes | ({16'd0, beat.data_byte} << (8 * word_phase));
         word_phase = word_phase + 2'd1;
         return;
      end
      word       = {beat.data_byte, word_bytes};
      word_bytes = '0;
      word_phase = '0;
      if (header_seen == 32'd4) begin
         if (word[1:0] != 2'd0) begin
            abort_list(STATUS_LENGTH, '0);
         end else if (word[31:2] > max_elems) begin
            abort_list(STATUS_LENGTH, word[31:2]);
         end else if (word[31:2] == 30'd0) begin
            expect_slice('0, '0, '0, '0, STATUS_OK, 1'b1);
            list_idle = 1'b1;
         end else begin
            list_count    = word[31:2];
            prev_boundary = word;
            elem_index    = '0;
            close_or_await();
         end
      end else if (word < prev_boundary || word > list_size) begin
         abort_list(STATUS_LENGTH, list_count);
      end else begin
         expect_slice(elem_index, prev_boundary, word - prev_boundary, list_count,
                      STATUS_OK, 1'b0);
         prev_boundary = word;
         elem_index    = elem_index + 30'd1;
         close_or_await();
      end
   endfunction

   // ------------------------------------------------------------------------------------
   // Stimulus building
   // ------------------------------------------------------------------------------------

   function automatic void queue_byte(input logic [7:0] value, input logic first,
                                      input logic [31:0] size);
      req_payload_type b;
      b.data_byte   = value;
      b.list_start  = first;
      b.buffer_size = size;
      header_beats.push_back(b);
      beats_queued++;
   endfunction

   // One little-endian offset. The buffer size only matters on a start beat, so the other
   // beats carry random sizes to exercise every bit of that field.
   function automatic void queue_word(input logic [31:0] word, input logic first,
                                      input logic [31:0] size);
      for (int i = 0; i < 4; i++)
         queue_byte(word[8*i +: 8], first && i == 0, (i == 0) ? size : $urandom);
   endfunction

   // Builds one list: a total size, an offset table that fits it, and then perhaps a
   // single defect. Only the header bytes count towards the random budget.
   function automatic void queue_random_list();
      logic [31:0]   bounds [$];
      logic [31:0]   total;
      logic [31:0]   head;
      logic [31:0]   pick;
      int unsigned   count;
      int unsigned   nbytes;
      int unsigned   k;
      int unsigned   r;
      list_flaw_type flaw;
      r = $urandom_range(99);
      if (r < 65)      flaw = FLAW_NONE;
      else if (r < 70) flaw = FLAW_MISALIGN;
      else if (r < 75) flaw = FLAW_OVERCOUNT;
      else if (r < 81) flaw = FLAW_BACKWARD;
      else if (r < 87) flaw = FLAW_BEYOND;
      else if (r < 90) flaw = FLAW_TRUNCATE;
      else if (r < 96) flaw = FLAW_RESTART;
      else             flaw = FLAW_NOISE;

      if (flaw == FLAW_NOISE) begin
         // Loose beats with the odd random start, tiny sizes included.
         repeat ($urandom_range(4, 1))
            queue_byte(8'($urandom), $urandom_range(3) == 0,
                       $urandom_range(1) ? $urandom : $urandom_range(12));
         return;
      end

      count = ($urandom_range(7) == 0) ? $urandom_range(12, 1) : $urandom_range(4, 1);
      if (flaw inside {FLAW_BACKWARD, FLAW_BEYOND, FLAW_TRUNCATE} && count < 2)
         count = 2;
      head = count * 4;
      if ($urandom_range(3) == 0)
         total = head + $urandom_range(32'hFFFF_FFFF - head, 0);
      else
         total = head + $urandom_range(48);
      bounds.push_back(head);
      for (int i = 1; i < count; i++) begin
         if ($urandom_range(15) == 0)
            bounds.push_back(total);
         else
            bounds.push_back(bounds[i-1] + $urandom_range((total - bounds[i-1]) / 2));
      end

      k = (count > 1) ? $urandom_range(count - 1, 1) : 0;
      case (flaw)
         FLAW_MISALIGN: begin
            bounds[0] = head + $urandom_range(3, 1);
         end
         FLAW_OVERCOUNT: begin
            if (max_elems == 30'h3FFF_FFFF)
               pick = $urandom;
            else
               pick = $urandom_range(32'h3FFF_FFFF, {2'b00, max_elems} + 32'd1);
            bounds[0] = {pick[29:0], 2'b00};
         end
         FLAW_BACKWARD: begin
            bounds[k] = bounds[k-1] - $urandom_range(bounds[k-1], 1);
         end
         FLAW_BEYOND: begin
            if (total != 32'hFFFF_FFFF)
               bounds[k] = total + $urandom_range(32'hFFFF_FFFF - total, 1);
         end
         FLAW_TRUNCATE: begin
            // Room for the first offset only, so the table runs off the buffer's end.
            total = $urandom_range(7, 4);
         end
         default: begin
         end
      endcase

      nbytes = (flaw == FLAW_RESTART) ? $urandom_range(4 * count - 1, 1) : 4 * count;
      for (int j = 0; j < nbytes; j++)
         queue_byte(8'(bounds[j / 4] >> (8 * (j % 4))), j == 0,
                    (j == 0) ? total : $urandom);
      header_count += nbytes;
      // Element payload that follows the table is ignored by the parser.
      if (flaw != FLAW_RESTART)
         repeat ($urandom_range(3))
            queue_byte(8'($urandom), 1'b0, $urandom);
   endfunction

   // ------------------------------------------------------------------------------------
   // Request driver: one beat per handshake, with random gaps between beats.
   // ------------------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_header_byte(req_data);
            beats_taken++;
         end
         // A beat that is still on offer stays put until it has been taken.
         if (!req_valid || req_ready) begin
            if (header_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= header_beats.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------------------
   // Response monitor: random back-pressure, and each beat checked field by field.
   // ------------------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
   endtask

   always @(posedge clock) begin : response_monitor
      rsp_payload_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (slice_expect.size() == 0) begin
               report_mismatch("unexpected beat, element_index",
                               32'(rsp_data.element_index), '0);
            end else begin
               want = slice_expect.pop_front();
               if (rsp_data.element_index !== want.element_index)
                  report_mismatch("element_index", 32'(rsp_data.element_index),
                                  32'(want.element_index));
               if (rsp_data.slice_start !== want.slice_start)
                  report_mismatch("slice_start", rsp_data.slice_start, want.slice_start);
               if (rsp_data.slice_length !== want.slice_length)
                  report_mismatch("slice_length", rsp_data.slice_length,
                                  want.slice_length);
               if (rsp_data.element_count !== want.element_count)
                  report_mismatch("element_count", 32'(rsp_data.element_count),
                                  32'(want.element_count));
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
               if (rsp_data.last !== want.last)
                  report_mismatch("last", 32'(rsp_data.last), 32'(want.last));
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------------------------
   // Sequencing of the run
   // ------------------------------------------------------------------------------------

   // Waits until every queued beat has been taken and every report has come back. The
   // parser decodes a beat in the cycle it is taken, so the closing wait is ample for
   // any beat that produced nothing.
   task automatic settle();
      while (beats_taken != beats_queued || slice_expect.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Callers are to write the limit register only while the parser sits idle; the task itself does not enforce this.
   task automatic write_max_elements(input logic [29:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      max_elems = value;
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [29:0] setting;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed beats, run with the limit still at its reset value of 1024 and light
      // idling on both sides.
      send_idle_pct  = 6;
      recv_stall_pct = 6;
      queue_byte(8'hA5, 1'b0, 32'd0);                     // idle byte, ignored
      queue_byte(8'hFF, 1'b1, 32'd0);                     // empty buffer
      queue_byte(8'($urandom), 1'b1, 32'd1);              // buffers too short for
      queue_byte(8'($urandom), 1'b1, 32'd2);              // even one offset
      queue_byte(8'($urandom), 1'b1, 32'd3);
      queue_word(32'd0, 1'b1, 32'd8);                     // zero elements
      queue_word(32'd6, 1'b1, 32'd100);                   // first offset not aligned
      queue_word(32'hFFFF_FFFC, 1'b1, 32'hFFFF_FFFF);     // count above the limit
      queue_word(32'd4, 1'b1, 32'hFFFF_FFFF);             // one element, largest buffer
      queue_word(32'd8, 1'b1, 32'd7);                     // table cut short by the size

      // Random lists under a series of limits, the extremes among them, each phase with
      // one of four patterns of idling.
      for (int p = 0; p < 6; p++) begin
         settle();
         case (p)
            0:       setting = 30'h3FFF_FFFF;
            1:       setting = 30'd0;
            2:       setting = 30'd3;
            3:       setting = 30'd1;
            4:       setting = MAX_ELEMENTS_RESET;
            default: setting = 30'($urandom_range(64, 2));
         endcase
         write_max_elements(setting);
         case (p % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 81;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 81;
            end
            default: begin
               send_idle_pct  = 6;
               recv_stall_pct = 6;
            end
         endcase
         header_count = 0;
         while (header_count < 88)
            queue_random_list();
      end

      settle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && slice_expect.size() == 0) begin
         $display("[ssz_offset_table_parser_top] OK");
      end else begin
         $display("[ssz_offset_table_parser_top] ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/sotp_pkg.sv
rtl/ssz_offset_table_parser_top.sv
test/tb_ssz_offset_table_parser_top.sv
